### hw/rtl/wfba_pkg.sv
// ----------------------------------------------------------------------------
// wfba_pkg: shared types and constants for the worst-fit block allocator
// Command and result records, operation codes and back-end states.
// ----------------------------------------------------------------------------
package wfba_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int IN_IDX_W = 4;
  localparam int AMT_W    = 16;
  localparam int CFG_W    = 5;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                ld_ok;   // load index is inside the block array
    logic [IN_IDX_W-1:0] idx;
    logic [AMT_W-1:0]    amount;
  } cmd_t;

  typedef struct packed {
    logic                granted;
    logic [IN_IDX_W-1:0] chosen_block;
    logic [AMT_W-1:0]    leftover;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_FINISH
  } back_state_t;

endpackage

### hw/rtl/wfba_queue.sv
// ----------------------------------------------------------------------------
// wfba_queue: small synchronous FIFO
// Register-based circular queue with a fill count; push blocked when full.
// ----------------------------------------------------------------------------
module wfba_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = CNT_W'(cnt_r + CNT_W'(do_push) - CNT_W'(do_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/wfba_front.sv
// ----------------------------------------------------------------------------
// wfba_front: input stage of the allocator
// Decodes each incoming transaction into a command and queues it.
// ----------------------------------------------------------------------------
module wfba_front #(
  parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_func,
  input  logic [wfba_pkg::IN_IDX_W-1:0] in_block_index,
  input  logic [wfba_pkg::AMT_W-1:0]    in_amount,
  input  logic                          cmd_pop,
  output logic                          cmd_valid,
  output wfba_pkg::cmd_t                cmd
);
  import wfba_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  // loads past the end of the array are kept as no-op commands
  always_comb begin
    cmd_in.op     = op_t'(in_func);
    cmd_in.ld_ok  = (9'(in_block_index) < 9'(MAX_BLOCKS));
    cmd_in.idx    = in_block_index;
    cmd_in.amount = in_amount;
  end

  wfba_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (cmd_in),
    .full    (in_full),
    .pop     (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

  assign cmd_valid = ~cmd_empty;

endmodule

### hw/rtl/wfba_back.sv
// ----------------------------------------------------------------------------
// wfba_back: execution stage of the allocator
// Holds block sizes and taken flags; runs loads and worst-fit scans.
// ----------------------------------------------------------------------------
module wfba_back #(
  parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wfba_pkg::CFG_W-1:0] block_count,
  input  logic                       cmd_valid,
  input  wfba_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output wfba_pkg::res_t             res
);
  import wfba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] rd_data_r;
  logic [MAX_BLOCKS-1:0] taken_r;

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [SIZE_BITS-1:0] amt_r, amt_nxt;
  logic                 found_r, found_nxt;
  logic [SIZE_BITS-1:0] best_left_r, best_left_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;

  logic                 rd_en, wr_en, set_taken;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [SIZE_BITS-1:0] cmd_amt;
  logic [31:0]          amt_ext, left_ext;
  logic [8:0]           idx_ext, chosen_ext, limit_ext;
  logic [CNT_W-1:0]     limit_now;
  logic [SIZE_BITS-1:0] left;
  logic                 fits, better;

  assign amt_ext    = 32'(cmd.amount);
  assign cmd_amt    = amt_ext[SIZE_BITS-1:0];
  assign idx_ext    = 9'(cmd.idx);
  assign wr_addr    = idx_ext[IDX_W-1:0];
  assign limit_ext  = (9'(block_count) > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : 9'(block_count);
  assign limit_now  = limit_ext[CNT_W-1:0];
  assign rd_addr    = cnt_r[IDX_W-1:0];
  assign left_ext   = 32'(best_left_r);
  assign chosen_ext = 9'(best_idx_r);

  // compare stage: one stored size per cycle
  assign left   = rd_data_r - amt_r;
  assign fits   = ~taken_r[cmp_idx_r] && (rd_data_r >= amt_r);
  assign better = ~found_r || (left > best_left_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    limit_nxt     = limit_r;
    amt_nxt       = amt_r;
    found_nxt     = found_r;
    best_left_nxt = best_left_r;
    best_idx_nxt  = best_idx_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res           = '0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    set_taken     = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_LOAD) begin
            wr_en    = cmd.ld_ok;
            res_push = 1'b1;
          end else if (limit_now == '0) begin
            res_push = 1'b1;
          end else begin
            amt_nxt       = cmd_amt;
            limit_nxt     = limit_now;
            cnt_nxt       = '0;
            found_nxt     = 1'b0;
            best_left_nxt = '0;
            best_idx_nxt  = '0;
            state_nxt     = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if ((cnt_r + 1'b1) == limit_r) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_nxt = BK_FINISH;
      end
      BK_FINISH: begin
        res_push         = 1'b1;
        res.granted      = found_r;
        res.chosen_block = chosen_ext[IN_IDX_W-1:0];
        res.leftover     = left_ext[AMT_W-1:0];
        set_taken        = found_r;
        state_nxt        = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase

    // strict greater keeps the lowest index on ties
    if (cmp_vld_r && fits && better) begin
      found_nxt     = 1'b1;
      best_left_nxt = left;
      best_idx_nxt  = cmp_idx_r;
    end
  end

  assign cmp_vld_nxt = rd_en;
  assign cmp_idx_nxt = rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      cmp_vld_r <= 1'b0;
      taken_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (wr_en) begin
        taken_r[wr_addr] <= 1'b0;
      end
      if (set_taken) begin
        taken_r[best_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    limit_r     <= limit_nxt;
    amt_r       <= amt_nxt;
    found_r     <= found_nxt;
    best_left_r <= best_left_nxt;
    best_idx_r  <= best_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
  end

  // size store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      size_mem[wr_addr] <= cmd_amt;
    end
    if (rd_en) begin
      rd_data_r <= size_mem[rd_addr];
    end
  end

endmodule

### hw/rtl/worst_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator: fixed-partition worst-fit allocator
// A load result is visible the cycle after accept. An allocate holds the back
// end through accept, scan of N = min(block_count, MAX_BLOCKS) blocks, drain
// and finish; otherwise one load per cycle while the result queue has room.
// Reset clears queues, taken flags and block_count; sizes are not cleared.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator #(
  parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transaction queue
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_func,
  input  logic [wfba_pkg::IN_IDX_W-1:0] in_block_index,
  input  logic [wfba_pkg::AMT_W-1:0]    in_amount,
  // result transaction queue
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_granted,
  output logic [wfba_pkg::IN_IDX_W-1:0] out_chosen_block,
  output logic [wfba_pkg::AMT_W-1:0]    out_leftover,
  // block_count register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wfba_pkg::CFG_W-1:0]    cfg_data
);
  import wfba_pkg::*;

  // Structure:
  //   front  - decodes func/index into a command, range-checks the load
  //            index, and parks it in a two-entry command queue.
  //   back   - owns the size store and taken flags. An allocate latches the
  //            request, streams the stored sizes through a registered read
  //            port one block per cycle, and keeps the running largest
  //            leftover; ties stay with the lower index.
  //   result - a two-entry queue decouples the back end from out_pop, so
  //            new commands keep flowing while a result waits.
  // The back end only starts a command when the result queue has room,
  // so each command's single result always has a slot.

  logic [CFG_W-1:0] block_count_r;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  // block_count must only be written while idle; not enforced here, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      block_count_r <= cfg_data;
    end
  end

  wfba_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_block_index (in_block_index),
    .in_amount      (in_amount),
    .cmd_pop        (cmd_pop),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd)
  );

  wfba_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .block_count (block_count_r),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res_in)
  );

  // result queue: oldest result is on the out_ ports while not empty
  wfba_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_out),
    .empty   (out_empty)
  );

  assign out_granted      = res_out.granted;
  assign out_chosen_block = res_out.chosen_block;
  assign out_leftover     = res_out.leftover;

endmodule
